[hw/rtl/dfpa_pkg.sv]
// Shared widths, sequencer states and unit control types for the dipole field accumulator.
package dfpa_pkg;

    localparam int ACC_WIDTH = 48;  // accumulator width, 32..64
    localparam int OUT_W     = 48;  // field and energy width
    localparam int MUL_W     = 36;  // shared multiplier operand width
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DEN_W     = 84;  // divisor width (|r|^3)
    localparam int REM_W     = 84;  // divider partial remainder
    localparam int DLOW_W    = 64;  // dividend bits shifted in, also quotient
    localparam int DCNT_W    = 7;
    localparam int RAD_W     = 56;  // square root radicand
    localparam int ROOT_W    = 28;

    localparam logic [0:0] REG_CUTOFF    = 1'b0;
    localparam logic [0:0] REG_PREFACTOR = 1'b1;

    typedef struct packed {
        logic              start;
        logic [DCNT_W-1:0] cnt;
    } t_div_ctl;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_SQ_ADD, S_CUT, S_CUT_CHK, S_SQRT, S_UDIV, S_UDIV_W,
        S_DOT, S_DOT_ADD, S_LEN2, S_LEN3A, S_LEN3B, S_LEN3C, S_BIG1, S_BIG2,
        S_BIG3, S_BIG4, S_V, S_V_ADD, S_T1, S_T2, S_T3, S_TDIV, S_TDIV_W,
        S_FIN, S_EHI, S_EHI_ADD, S_ELO_ADD, S_OUT
    } t_state;

endpackage

[hw/rtl/dipole_field_pair_accumulator.sv]
// Top level: dipole field pair accumulator, sequencer and datapath.
//
// Usage: one beat on the slave stream is one (target, source) pair.
// tlast marks the final pair of a target spin. Pairs with zero
// displacement or beyond the cutoff add nothing. On the tlast pair the
// block emits one master beat carrying field x/y/z and the energy
// -0.5 s_i.h (Q16.32, saturated), then clears its sums.
// Config channel: index 0 = cutoff radius, index 1 = field prefactor;
// always ready, write only while no pair is in flight.
// Timing: o_s_tready is high only in idle, so a pair inside the cutoff
// is finished before the next accept: a 28-step root, three 16-step
// divides for the unit vector and up to three (ACC_WIDTH-1) step
// divides for the field terms, all on one multiplier, one square root
// unit and one divider; a field divide is skipped when its term saturates.
// The result sits in an output register; if the receiver stalls, the
// next pairs are still taken up to the next tlast, which waits until
// the held beat is gone. Reset (i_rst_n low, synchronous) clears the
// sums, restores the register defaults and drops o_m_tvalid.
module dipole_field_pair_accumulator import dfpa_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [0:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // disp_x, disp_y, disp_z, src_spin_x, src_spin_y, src_spin_z,
    // src_moment, tgt_moment, tgt_spin_x, tgt_spin_y, tgt_spin_z
    input  logic [199:0] i_s_tdata,
    input  logic         i_s_tlast,  // last_pair
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // field_x, field_y, field_z, spin_energy
    output logic [191:0] o_m_tdata
);

    localparam int AW  = ACC_WIDTH;
    localparam int XW  = 121;           // big*|v|*2^22
    localparam int LSH = DLOW_W - (AW - 1);

    // control and config
    t_state r_state, n_state;
    logic [1:0]  r_n;
    logic [22:0] r_cut_rad;
    logic [31:0] r_pref;
    logic signed [AW-1:0] r_acc [3];
    logic r_m_valid;

    // payload
    logic signed [23:0] r_r [3];
    logic signed [15:0] r_s [3];
    logic signed [15:0] r_t [3];
    logic [15:0] r_mi, r_mj;
    logic        r_last;
    logic [47:0] r_q;
    logic [ROOT_W-1:0] r_len;
    logic signed [16:0] r_u [3];
    logic signed [33:0] r_dot;
    logic signed [18:0] r_p15;
    logic [27:0] r_len2hi;
    logic [DEN_W-1:0] r_len3;
    logic [23:0] r_pmhi;
    logic [63:0] r_big;
    logic [34:0] r_magv;
    logic        r_vneg;
    logic [98:0] r_x0;
    logic signed [65:0] r_esum;
    logic [191:0] r_m_data;

    // unit hookups
    logic signed [MUL_W-1:0]  w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic                     w_sqrt_start, w_sqrt_done;
    logic [ROOT_W-1:0]        w_root;
    t_div_ctl                 w_div_ctl;
    logic [REM_W-1:0]         w_div_rem;
    logic [DLOW_W-1:0]        w_div_low;
    logic [DEN_W-1:0]         w_div_den;
    logic                     w_div_done;
    logic [DLOW_W-1:0]        w_quo;

    // datapath helpers
    logic        w_accept;
    logic        w_skip;
    logic [23:0] w_rmag;
    logic        w_out_go;
    logic [33:0] w_dmag;
    logic [18:0] w_p15m;
    logic signed [38:0] w_v;
    logic [38:0] w_vmag;
    logic [XW-1:0] w_x;
    logic [XW-1:0] w_trem;
    logic          w_tsat;
    logic [AW-2:0] w_tmag;
    logic signed [AW:0] w_term, w_sum;
    logic signed [AW-1:0] w_acc_new;
    logic          w_acc_upd;
    logic signed [OUT_W-1:0] w_h;
    logic signed [OUT_W-1:0] w_hx, w_hy, w_hz, w_e;
    logic signed [66:0] w_eneg;

    function automatic logic signed [OUT_W-1:0] f_clamp(input logic signed [66:0] v);
        logic signed [66:0] hi;
        logic signed [66:0] lo;
        hi = 67'((68'sd1 <<< (OUT_W - 1)) - 1);
        lo = -hi - 67'sd1;
        if (v > hi) f_clamp = hi[OUT_W-1:0];
        else if (v < lo) f_clamp = lo[OUT_W-1:0];
        else f_clamp = v[OUT_W-1:0];
    endfunction

    dfpa_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    dfpa_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_rad   ({r_q, 8'b0}),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    dfpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_rem   (w_div_rem),
        .i_low   (w_div_low),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_out_go = !r_m_valid || i_m_tready;
    assign w_skip   = (r_q == '0) || (r_q > w_prod[47:0]);
    assign w_rmag   = r_r[r_n][23] ? 24'(-r_r[r_n]) : r_r[r_n];

    // dot product rounding, half away from zero
    assign w_dmag = r_dot[33] ? 34'(-r_dot) : r_dot;
    assign w_p15m = 19'((35'(w_dmag) + 35'd16384) >> 15);

    // v = 3*u*p15 - s*2^15
    assign w_v    = 39'(3 * 39'($signed(w_prod[35:0])))
                  - (39'(r_s[r_n]) <<< 15);
    assign w_vmag = w_v[38] ? 39'(-w_v) : w_v;

    // term division: sat when the quotient would not fit AW-1 bits
    assign w_x    = {r_x0, 22'b0};
    assign w_trem = w_x >> (AW - 1);
    assign w_tsat = w_trem >= XW'(r_len3);
    assign w_tmag = (r_state == S_TDIV) ? '1 : w_quo[AW-2:0];
    assign w_term = r_vneg ? -(AW+1)'({2'b00, w_tmag}) : (AW+1)'({2'b00, w_tmag});
    assign w_sum  = (AW+1)'(r_acc[r_n]) + w_term;
    always_comb begin
        if (w_sum[AW] != w_sum[AW-1])
            w_acc_new = w_sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        else
            w_acc_new = w_sum[AW-1:0];
    end
    assign w_acc_upd = ((r_state == S_TDIV) && w_tsat)
                    || ((r_state == S_TDIV_W) && w_div_done);

    // output side
    assign w_h    = f_clamp(67'(r_acc[r_n]));
    assign w_hx   = f_clamp(67'(r_acc[0]));
    assign w_hy   = f_clamp(67'(r_acc[1]));
    assign w_hz   = f_clamp(67'(r_acc[2]));
    assign w_eneg = -67'(r_esum >>> 16);
    assign w_e    = f_clamp(w_eneg);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_s_tvalid) n_state = S_SQ;
            S_SQ:      n_state = S_SQ_ADD;
            S_SQ_ADD:  n_state = (r_n == 2'd2) ? S_CUT : S_SQ;
            S_CUT:     n_state = S_CUT_CHK;
            S_CUT_CHK: n_state = w_skip ? S_FIN : S_SQRT;
            S_SQRT:    if (w_sqrt_done) n_state = S_UDIV;
            S_UDIV:    n_state = S_UDIV_W;
            S_UDIV_W:  if (w_div_done) n_state = (r_n == 2'd2) ? S_DOT : S_UDIV;
            S_DOT:     n_state = S_DOT_ADD;
            S_DOT_ADD: n_state = (r_n == 2'd2) ? S_LEN2 : S_DOT;
            S_LEN2:    n_state = S_LEN3A;
            S_LEN3A:   n_state = S_LEN3B;
            S_LEN3B:   n_state = S_LEN3C;
            S_LEN3C:   n_state = S_BIG1;
            S_BIG1:    n_state = S_BIG2;
            S_BIG2:    n_state = S_BIG3;
            S_BIG3:    n_state = S_BIG4;
            S_BIG4:    n_state = S_V;
            S_V:       n_state = S_V_ADD;
            S_V_ADD:   n_state = S_T1;
            S_T1:      n_state = S_T2;
            S_T2:      n_state = S_T3;
            S_T3:      n_state = S_TDIV;
            S_TDIV: begin
                if (w_tsat) n_state = (r_n == 2'd2) ? S_FIN : S_V;
                else        n_state = S_TDIV_W;
            end
            S_TDIV_W:  if (w_div_done) n_state = (r_n == 2'd2) ? S_FIN : S_V;
            S_FIN:     n_state = r_last ? S_EHI : S_IDLE;
            S_EHI:     n_state = S_EHI_ADD;
            S_EHI_ADD: n_state = S_ELO_ADD;
            S_ELO_ADD: n_state = (r_n == 2'd2) ? S_OUT : S_EHI;
            S_OUT:     if (w_out_go) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // unit operands and handshake outputs
    always_comb begin
        w_mul_a       = '0;
        w_mul_b       = '0;
        w_sqrt_start  = 1'b0;
        w_div_ctl     = '0;
        w_div_rem     = REM_W'({w_rmag, 3'b000});
        w_div_low     = '0;
        w_div_den     = DEN_W'(r_len);
        o_s_tready    = 1'b0;
        unique case (r_state)
            S_IDLE:    o_s_tready = 1'b1;
            S_SQ: begin
                w_mul_a = MUL_W'(r_r[r_n]);
                w_mul_b = MUL_W'(r_r[r_n]);
            end
            S_CUT: begin
                w_mul_a = MUL_W'({1'b0, r_cut_rad});
                w_mul_b = MUL_W'({1'b0, r_cut_rad});
            end
            S_CUT_CHK: w_sqrt_start = !w_skip;
            S_UDIV: begin
                w_div_ctl.start = 1'b1;
                w_div_ctl.cnt   = DCNT_W'(16);
            end
            S_DOT: begin
                w_mul_a = MUL_W'(r_s[r_n]);
                w_mul_b = MUL_W'(r_u[r_n]);
            end
            S_LEN2: begin
                w_mul_a = MUL_W'({1'b0, r_len});
                w_mul_b = MUL_W'({1'b0, r_len});
            end
            S_LEN3A: begin
                w_mul_a = MUL_W'({1'b0, w_prod[27:0]});
                w_mul_b = MUL_W'({1'b0, r_len});
            end
            S_LEN3B: begin
                w_mul_a = MUL_W'({1'b0, r_len2hi});
                w_mul_b = MUL_W'({1'b0, r_len});
            end
            S_BIG1: begin
                w_mul_a = MUL_W'({1'b0, r_pref});
                w_mul_b = MUL_W'({1'b0, r_mi});
            end
            S_BIG2: begin
                w_mul_a = MUL_W'({1'b0, w_prod[23:0]});
                w_mul_b = MUL_W'({1'b0, r_mj});
            end
            S_BIG3: begin
                w_mul_a = MUL_W'({1'b0, r_pmhi});
                w_mul_b = MUL_W'({1'b0, r_mj});
            end
            S_V: begin
                w_mul_a = MUL_W'(r_u[r_n]);
                w_mul_b = MUL_W'(r_p15);
            end
            S_T1: begin
                w_mul_a = MUL_W'({1'b0, r_big[31:0]});
                w_mul_b = MUL_W'({1'b0, r_magv});
            end
            S_T2: begin
                w_mul_a = MUL_W'({1'b0, r_big[63:32]});
                w_mul_b = MUL_W'({1'b0, r_magv});
            end
            S_TDIV: begin
                w_div_ctl.start = !w_tsat;
                w_div_ctl.cnt   = DCNT_W'(AW - 1);
                w_div_rem       = w_trem[REM_W-1:0];
                w_div_low       = DLOW_W'(w_x[AW-2:0]) << LSH;
                w_div_den       = r_len3;
            end
            S_EHI: begin
                w_mul_a = MUL_W'(r_t[r_n]);
                w_mul_b = MUL_W'($signed(w_h[OUT_W-1:24]));
            end
            S_EHI_ADD: begin
                w_mul_a = MUL_W'(r_t[r_n]);
                w_mul_b = MUL_W'({1'b0, w_h[23:0]});
            end
            default: ;
        endcase
    end

    // control state, config and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_n       <= '0;
            r_cut_rad <= 23'd196608;
            r_pref    <= '0;
            r_m_valid <= 1'b0;
            for (int i = 0; i < 3; i++) r_acc[i] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_CUTOFF:    r_cut_rad <= i_cfg_data[22:0];
                    REG_PREFACTOR: r_pref    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) r_n <= '0;
            else if ((r_state == S_SQ_ADD) || (r_state == S_DOT_ADD)
                     || (r_state == S_ELO_ADD)
                     || ((r_state == S_UDIV_W) && w_div_done) || w_acc_upd)
                r_n <= (r_n == 2'd2) ? 2'd0 : r_n + 2'd1;
            else if (r_state == S_FIN) r_n <= '0;
            if (w_acc_upd) r_acc[r_n] <= w_acc_new;
            if ((r_state == S_FIN) && !r_last) begin
                // non-final pair keeps the sums
            end
            if ((r_state == S_OUT) && w_out_go) begin
                r_m_valid <= 1'b1;
                for (int i = 0; i < 3; i++) r_acc[i] <= '0;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_r[0] <= i_s_tdata[23:0];
            r_r[1] <= i_s_tdata[47:24];
            r_r[2] <= i_s_tdata[71:48];
            r_s[0] <= i_s_tdata[87:72];
            r_s[1] <= i_s_tdata[103:88];
            r_s[2] <= i_s_tdata[119:104];
            r_mj   <= i_s_tdata[135:120];
            r_mi   <= i_s_tdata[151:136];
            r_t[0] <= i_s_tdata[167:152];
            r_t[1] <= i_s_tdata[183:168];
            r_t[2] <= i_s_tdata[199:184];
            r_last <= i_s_tlast;
            r_q    <= '0;
            r_dot  <= '0;
            r_esum <= '0;
        end
        unique case (r_state)
            S_SQ_ADD:  r_q <= r_q + w_prod[47:0];
            S_SQRT:    if (w_sqrt_done) r_len <= w_root;
            S_UDIV_W: begin
                if (w_div_done)
                    r_u[r_n] <= r_r[r_n][23] ? 17'(-$signed({1'b0, w_quo[15:0]}))
                                             : $signed({1'b0, w_quo[15:0]});
            end
            S_DOT_ADD: r_dot <= r_dot + w_prod[33:0];
            S_LEN2:    r_p15 <= r_dot[33] ? 19'(-w_p15m) : w_p15m;
            S_LEN3A:   r_len2hi <= w_prod[55:28];
            S_LEN3B:   r_len3 <= DEN_W'(w_prod[55:0]);
            S_LEN3C:   r_len3 <= r_len3 + {w_prod[55:0], 28'b0};
            S_BIG2:    r_pmhi <= w_prod[47:24];
            S_BIG3:    r_big <= 64'(w_prod[39:0]);
            S_BIG4:    r_big <= r_big + {w_prod[39:0], 24'b0};
            S_V_ADD: begin
                r_magv <= w_vmag[34:0];
                r_vneg <= w_v[38];
            end
            S_T2:      r_x0 <= 99'(w_prod[66:0]);
            S_T3:      r_x0 <= r_x0 + {w_prod[66:0], 32'b0};
            S_EHI_ADD: r_esum <= r_esum + 66'($signed({w_prod[39:0], 24'b0}));
            S_ELO_ADD: r_esum <= r_esum + 66'($signed(w_prod[40:0]));
            S_OUT: begin
                if (w_out_go) r_m_data <= {w_e, w_hz, w_hy, w_hx};
            end
            default: ;
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;

endmodule

[hw/rtl/dfpa_mul.sv]
// Shared signed multiplier with registered product.
module dfpa_mul import dfpa_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

[hw/rtl/dfpa_div.sv]
// Restoring divider, one quotient bit per cycle.
module dfpa_div import dfpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_ctl          i_ctl,
    input  logic [REM_W-1:0]  i_rem,   // dividend bits above the ones shifted in
    input  logic [DLOW_W-1:0] i_low,   // dividend bits shifted in, MSB first
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_done,
    output logic [DLOW_W-1:0] o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [REM_W-1:0]  r_rem;
    logic [DLOW_W-1:0] r_low;
    logic [DLOW_W-1:0] r_quo;
    logic [DEN_W-1:0]  r_den;
    logic [REM_W:0]    w_remx;
    logic [REM_W:0]    w_diff;
    logic              w_ge;

    assign w_remx = {r_rem, r_low[DLOW_W-1]};
    assign w_diff = w_remx - {1'b0, r_den};
    assign w_ge   = w_remx >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.cnt;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= i_rem;
            r_low <= i_low;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[REM_W-1:0] : w_remx[REM_W-1:0];
            r_low <= {r_low[DLOW_W-2:0], 1'b0};
            r_quo <= {r_quo[DLOW_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[hw/rtl/dfpa_sqrt.sv]
// Integer square root, two radicand bits per cycle.
module dfpa_sqrt import dfpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_rad,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic                r_busy;
    logic                r_done;
    logic [4:0]          r_cnt;
    logic [RAD_W-1:0]    r_rad;
    logic [ROOT_W+1:0]   r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [ROOT_W+3:0]   w_remx;
    logic [ROOT_W+3:0]   w_trial;
    logic [ROOT_W+3:0]   w_diff;
    logic                w_ge;

    assign w_remx  = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_diff  = w_remx - w_trial;
    assign w_ge    = w_remx >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(ROOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[ROOT_W+1:0] : w_remx[ROOT_W+1:0];
            r_root <= {r_root[ROOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[hw/rtl/dfpa_chk.sv]
// Port-level checker for the dipole field accumulator, bound to the top level.
module dfpa_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_cfg_valid,
    input logic         o_cfg_ready,
    input logic [0:0]   i_cfg_index,
    input logic [31:0]  i_cfg_data,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [199:0] i_s_tdata,
    input logic         i_s_tlast,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [191:0] o_m_tdata
);

    // busy right after taking a pair
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready stayed high after an input beat");

    // a result never appears in the cycle after a pair is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !$rose(o_m_tvalid))
        else $error("result appeared one cycle after an input beat");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // held result is not lost or changed under stall
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output beat changed under stall");

endmodule

bind dipole_field_pair_accumulator dfpa_chk u_dfpa_chk (.*);
